/* rtl/core/hcbp_pkg.sv */
// Huffman code bit packer: shared types and constants.
// Used by the controller, the datapath and the top level.
package hcbp_pkg;

	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int SYM_W        = 8;
	localparam int KIND_W       = 2;
	localparam int ACC_W        = CODE_W + 7;
	localparam int TOTAL_W      = 6;
	localparam int MAX_CODE_LEN = 32;
	localparam int ENTRY_W      = CODE_W + LEN_W;
	localparam int TABLE_DEPTH  = 256;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

	typedef struct packed {
		logic merge;
		logic emit;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic has_byte;
		logic final_byte;
		logic out_free;
	} status_t;

endpackage

/* rtl/core/hcbp_ctrl.sv */
// Huffman code bit packer controller: sequences lookup, merge, byte emission and flush.
// Depends on hcbp_pkg for command and status types and kind codes.
module hcbp_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [hcbp_pkg::KIND_W-1:0] kind,
	output logic                         in_ready,
	input  hcbp_pkg::status_t            status,
	output hcbp_pkg::cmd_t               cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOOK:  cmd.merge = 1'b1;
			ST_EMIT:  cmd.emit  = status.has_byte && status.out_free;
			ST_FLUSH: cmd.flush = status.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && kind == hcbp_pkg::KIND_ENCODE) begin
						state_q <= ST_LOOK;
					end else if (accept && kind == hcbp_pkg::KIND_FLUSH) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_LOOK: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!status.has_byte) begin
						state_q <= ST_IDLE;
					end else if (status.out_free && status.final_byte) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.emit && !cmd.flush && !cmd.merge)
		else $error("command issued while idle");

	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free && status.has_byte)
		else $error("emit without byte or space");

	a_merge_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == hcbp_pkg::KIND_ENCODE) |=> cmd.merge)
		else $error("encode not merged after lookup");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> in_ready)
		else $error("flush did not return to idle");

endmodule

/* rtl/core/hcbp_dp.sv */
// Huffman code bit packer datapath: code table memory, bit accumulator, output register.
// Depends on hcbp_pkg; driven by commands from hcbp_ctrl.
module hcbp_dp #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [hcbp_pkg::KIND_W-1:0]  kind,
	input  logic [hcbp_pkg::SYM_W-1:0]   symbol,
	input  logic [hcbp_pkg::CODE_W-1:0]  code_bits,
	input  logic [hcbp_pkg::LEN_W-1:0]   code_length,
	input  hcbp_pkg::cmd_t                cmd,
	output hcbp_pkg::status_t             status,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic [3:0]                    pad_bits,
	output logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready
);

	localparam int LEN_LIM = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
		: hcbp_pkg::CODE_W;
	localparam logic [hcbp_pkg::LEN_W-1:0] LEN_LIM_V = hcbp_pkg::LEN_W'(LEN_LIM);

	logic [hcbp_pkg::ENTRY_W-1:0]  mem [hcbp_pkg::TABLE_DEPTH];
	logic [hcbp_pkg::ENTRY_W-1:0]  entry_q;
	logic [hcbp_pkg::LEN_W-1:0]    len_sat;
	logic [hcbp_pkg::LEN_W-1:0]    e_len;
	logic [hcbp_pkg::CODE_W-1:0]   e_code;
	logic [hcbp_pkg::CODE_W-1:0]   mask;
	logic [hcbp_pkg::ACC_W-1:0]    acc_q;
	logic [hcbp_pkg::TOTAL_W-1:0]  total_q;
	logic [hcbp_pkg::TOTAL_W-1:0]  emit_sh;
	logic [hcbp_pkg::ACC_W-1:0]    emit_acc;
	logic [2:0]                    cnt;
	logic [3:0]                    pad;
	logic [7:0]                    flush_byte;

	assign len_sat = (code_length > LEN_LIM_V) ? LEN_LIM_V : code_length;

	always_ff @(posedge clk) begin
		if (accept && kind == hcbp_pkg::KIND_LOAD) begin
			mem[symbol] <= {len_sat, code_bits};
		end
		if (accept) begin
			entry_q <= mem[symbol];
		end
	end

	assign e_code = entry_q[hcbp_pkg::CODE_W-1:0];
	assign e_len  = entry_q[hcbp_pkg::ENTRY_W-1:hcbp_pkg::CODE_W];
	assign mask   = ~({hcbp_pkg::CODE_W{1'b1}} << e_len);

	assign emit_sh    = total_q - hcbp_pkg::TOTAL_W'(8);
	assign emit_acc   = acc_q >> emit_sh;
	assign cnt        = total_q[2:0];
	assign pad        = 4'd8 - {1'b0, cnt};
	assign flush_byte = (cnt == 3'd0) ? 8'd0 : 8'(acc_q[7:0] << pad);

	assign status.has_byte   = (total_q >= hcbp_pkg::TOTAL_W'(8));
	assign status.final_byte = (total_q < hcbp_pkg::TOTAL_W'(16));
	assign status.out_free   = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.merge) begin
				total_q <= total_q + hcbp_pkg::TOTAL_W'(e_len);
			end else if (cmd.emit) begin
				total_q <= emit_sh;
			end else if (cmd.flush) begin
				total_q <= '0;
			end
			if (cmd.emit || cmd.flush) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.merge) begin
			acc_q <= (acc_q << e_len) | hcbp_pkg::ACC_W'(e_code & mask);
		end
		if (cmd.emit) begin
			out_byte   <= emit_acc[7:0];
			byte_valid <= 1'b1;
			pad_bits   <= 4'd0;
			last       <= status.final_byte;
		end else if (cmd.flush) begin
			out_byte   <= flush_byte;
			byte_valid <= (cnt != 3'd0);
			pad_bits   <= pad;
			last       <= 1'b1;
		end
	end

endmodule

/* rtl/core/huffman_code_bit_packer.sv */
// Huffman code bit packer top level: joins hcbp_ctrl and hcbp_dp.
// Sequence: an accepted encode is merged in ST_LOOK, then its bytes leave from ST_EMIT.
// Items are taken one at a time; an encode gives N bytes (N 0..4), a flush one word, a load
// none; no new item is taken until the controller is idle, and output waits on out_ready.
// Reset: arst_n clears the accumulator count, controller and output valid; the code
// table has no reset and must be loaded before use.
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hcbp_pkg::KIND_W-1:0]  kind,
	input  logic [hcbp_pkg::SYM_W-1:0]   symbol,
	input  logic [hcbp_pkg::CODE_W-1:0]  code_bits,
	input  logic [hcbp_pkg::LEN_W-1:0]   code_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic [3:0]                    pad_bits,
	output logic                          last
);

	hcbp_pkg::cmd_t    cmd;
	hcbp_pkg::status_t status;
	logic              accept;

	assign accept = in_valid && in_ready;

	hcbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	hcbp_dp #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (kind),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.cmd         (cmd),
		.status      (status),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.pad_bits    (pad_bits),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule

/* dv/testbench.sv */
// Testbench for huffman_code_bit_packer: code table loads, symbol encodes and flushes,
// checked word by word against a behavioural packer model held in a scoreboard class.
// Depends on hcbp_pkg and the huffman_code_bit_packer RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN_LIMIT  = (hcbp_pkg::MAX_CODE_LEN < 32) ? hcbp_pkg::MAX_CODE_LEN : 32;
	localparam int STALL_MAX  = 4000;
	localparam int TAIL_WAIT  = 20;
	localparam int RAND_ITEMS = 220;
	localparam logic [hcbp_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic [3:0] pad;
		logic       last;
	} packed_word_t;

	class packer_scoreboard;
		logic [hcbp_pkg::CODE_W-1:0] code_word [hcbp_pkg::TABLE_DEPTH];
		logic [hcbp_pkg::LEN_W-1:0]  code_len [hcbp_pkg::TABLE_DEPTH];
		logic [6:0]                  held_bits;
		int unsigned                 held_count;
		packed_word_t                due_words [$];
		int unsigned                 mismatches;

		function new();
			held_bits  = '0;
			held_count = 0;
			mismatches = 0;
		endfunction

		function void flag(string what, packed_word_t exp, packed_word_t obs);
			mismatches++;
			if (mismatches <= 10)
				$display("%t %s: expected byte %02h valid %0d pad %0d last %0d,",
					$realtime, what, exp.data, exp.valid, exp.pad, exp.last,
					" got byte %02h valid %0d pad %0d last %0d",
					obs.data, obs.valid, obs.pad, obs.last);
		endfunction

		function void note_word(logic [hcbp_pkg::KIND_W-1:0] k,
				logic [hcbp_pkg::SYM_W-1:0] sym,
				logic [hcbp_pkg::CODE_W-1:0] bits, logic [hcbp_pkg::LEN_W-1:0] len);
			logic [63:0] acc;
			int unsigned width;
			int unsigned total;
			int n;
			packed_word_t w;
			case (k)
				hcbp_pkg::KIND_LOAD: begin
					code_word[sym] = bits;
					code_len[sym]  = (len > LEN_LIMIT) ? hcbp_pkg::LEN_W'(LEN_LIMIT) : len;
				end
				hcbp_pkg::KIND_ENCODE: begin
					width = code_len[sym];
					acc = (64'(held_bits) << width) |
						(64'(code_word[sym]) & ((64'd1 << width) - 64'd1));
					total = held_count + width;
					n = 0;
					while (total >= 8 && n < 4) begin
						total  -= 8;
						w.data  = 8'(acc >> total);
						w.valid = 1'b1;
						w.pad   = 4'd0;
						w.last  = 1'b0;
						due_words.push_back(w);
						n++;
					end
					if (n > 0)
						due_words[due_words.size()-1].last = 1'b1;
					held_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
					held_count = total;
				end
				hcbp_pkg::KIND_FLUSH: begin
					if (held_count > 0) begin
						w.data  = 8'({1'b0, held_bits} << (8 - held_count));
						w.valid = 1'b1;
						w.pad   = 4'(8 - held_count);
					end else begin
						w.data  = 8'd0;
						w.valid = 1'b0;
						w.pad   = 4'd8;
					end
					w.last = 1'b1;
					due_words.push_back(w);
					held_bits  = '0;
					held_count = 0;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_word(packed_word_t obs);
			packed_word_t exp;
			if (due_words.size() == 0) begin
				exp = '0;
				flag("unexpected word", exp, obs);
			end else begin
				exp = due_words.pop_front();
				if (obs !== exp)
					flag("word mismatch", exp, obs);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [hcbp_pkg::KIND_W-1:0]   kind;
	logic [hcbp_pkg::SYM_W-1:0]    symbol;
	logic [hcbp_pkg::CODE_W-1:0]   code_bits;
	logic [hcbp_pkg::LEN_W-1:0]    code_length;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [7:0]                    out_byte;
	logic                          byte_valid;
	logic [3:0]                    pad_bits;
	logic                          last;

	packer_scoreboard           sb = new();
	bit                         calm;
	int unsigned                quiet_cycles = 0;
	bit                         stocked [hcbp_pkg::TABLE_DEPTH];
	logic [hcbp_pkg::SYM_W-1:0] stock_list [$];

	huffman_code_bit_packer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.symbol     (symbol),
		.code_bits  (code_bits),
		.code_length(code_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.pad_bits   (pad_bits),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_word({out_byte, byte_valid, pad_bits, last});
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [hcbp_pkg::KIND_W-1:0] k,
			input logic [hcbp_pkg::SYM_W-1:0] s,
			input logic [hcbp_pkg::CODE_W-1:0] b, input logic [hcbp_pkg::LEN_W-1:0] l);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		symbol      <= s;
		code_bits   <= b;
		code_length <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_word(k, s, b, l);
		if (k == hcbp_pkg::KIND_LOAD && !stocked[s]) begin
			stocked[s] = 1'b1;
			stock_list.push_back(s);
		end
	endtask

	// hold the sender until every outstanding word has come back
	task automatic drain_words();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.due_words.size() != 0);
	endtask

	task automatic load_random();
		logic [hcbp_pkg::LEN_W-1:0] l;
		int unsigned                pick;
		pick = $urandom_range(99);
		if (pick < 70)
			l = hcbp_pkg::LEN_W'($urandom_range(12, 1));
		else if (pick < 85)
			l = hcbp_pkg::LEN_W'($urandom_range(32, 13));
		else if (pick < 95)
			l = hcbp_pkg::LEN_W'($urandom_range(63, 33));
		else
			l = '0;
		send_word(hcbp_pkg::KIND_LOAD, hcbp_pkg::SYM_W'($urandom_range(255)), $urandom, l);
	endtask

	initial begin
		int unsigned sent;
		int unsigned pick;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		kind         <= hcbp_pkg::KIND_LOAD;
		symbol       <= '0;
		code_bits    <= '0;
		code_length  <= '0;
		calm         = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(hcbp_pkg::KIND_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd0);
		send_word(hcbp_pkg::KIND_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
		send_word(hcbp_pkg::KIND_LOAD,   8'h01, 32'hAAAA_AAAA, 6'd63);
		send_word(hcbp_pkg::KIND_LOAD,   8'h02, 32'h5555_5555, 6'd33);
		send_word(hcbp_pkg::KIND_LOAD,   8'h03, 32'hFFFF_FFFF, 6'd1);
		send_word(hcbp_pkg::KIND_LOAD,   8'h04, 32'h1234_565A, 6'd7);
		send_word(hcbp_pkg::KIND_LOAD,   8'h80, 32'h0000_00C3, 6'd8);
		send_word(hcbp_pkg::KIND_FLUSH,  8'h00, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_ENCODE, 8'h00, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_ENCODE, 8'h03, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_FLUSH,  8'h00, 32'h0, 6'd0);
		drain_words();
		send_word(hcbp_pkg::KIND_ENCODE, 8'h01, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_ENCODE, 8'h03, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_ENCODE, 8'h04, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_ENCODE, 8'h80, 32'h0, 6'd0);
		send_word(KIND_SPARE,            8'hFF, 32'hFFFF_FFFF, 6'd63);
		send_word(hcbp_pkg::KIND_ENCODE, 8'h02, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_ENCODE, 8'h04, 32'h0, 6'd0);
		send_word(hcbp_pkg::KIND_FLUSH,  8'h00, 32'h0, 6'd0);
		repeat (8) load_random();

		sent = 0;
		while (sent < RAND_ITEMS) begin
			calm = (sent >= 80 && sent < 140);
			if (sent == 180)
				drain_words();
			pick = $urandom_range(99);
			if (pick < 15) begin
				load_random();
				sent++;
			end else if (pick < 85) begin
				send_word(hcbp_pkg::KIND_ENCODE,
					stock_list[$urandom_range(stock_list.size()-1)],
					$urandom, hcbp_pkg::LEN_W'($urandom_range(63)));
				sent++;
			end else if (pick < 95) begin
				send_word(hcbp_pkg::KIND_FLUSH, hcbp_pkg::SYM_W'($urandom_range(255)),
					$urandom, hcbp_pkg::LEN_W'($urandom_range(63)));
				sent++;
			end else begin
				send_word(KIND_SPARE, hcbp_pkg::SYM_W'($urandom_range(255)), $urandom,
					hcbp_pkg::LEN_W'($urandom_range(63)));
			end
		end
		calm = 1'b0;
		send_word(hcbp_pkg::KIND_FLUSH, 8'h00, 32'h0, 6'd0);

		in_valid <= 1'b0;
		do @(posedge clk); while (sb.due_words.size() != 0);
		repeat (TAIL_WAIT) @(posedge clk);
		sb.mismatches += sb.due_words.size();
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
